@@ hdl/decv_pkg.sv @@
// Shared types and constants for the dual encoder counter and velocity core.
`default_nettype none
package decv_pkg;

   // Configuration register indexes
   localparam logic [1:0] REG_DISTANCE_PER_TICK = 2'd0;
   localparam logic [1:0] REG_LEFT_POLARITY     = 2'd1;
   localparam logic [1:0] REG_RIGHT_POLARITY    = 2'd2;

   // Reset values of the configuration registers
   localparam logic [15:0] DISTANCE_RESET       = 16'd155;
   localparam logic        LEFT_POLARITY_RESET  = 1'b0;
   localparam logic        RIGHT_POLARITY_RESET = 1'b1;

   // um/us to mm/s scale and width of distance * scale
   localparam int          K_BITS   = 26;
   localparam logic [9:0]  MM_SCALE = 10'd1000;

   // Interval field width
   localparam int          IV_BITS  = 20;

   // Saturation limits of the 32-bit velocity
   localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

   // Command from the top level to one lane
   typedef struct packed {
      logic step;
      logic func;
      logic a;
      logic b;
      logic pol;
   } lane_cmd_type;

   // Status from one lane to the merging stage
   typedef struct packed {
      logic        done;
      logic [31:0] ticks;
      logic [31:0] speed;
   } lane_status_type;

endpackage
`default_nettype wire

@@ hdl/dual_encoder_counter_velocity_core.sv @@
// Top level: configuration, input beat control, two encoder lanes and result merge.
//
// Input channel req_*: one beat samples both encoders (tdata) and says with
// tuser whether velocities are measured too. Result channel rsp_*: one beat
// per input beat, carrying both tick counts and both velocities, with tuser
// flagging a measured result. Configuration csr_*: a write lands on the edge
// where csr_we is high; index 0 distance per tick, 1 left polarity, 2 right
// polarity.
// Sequence: a sample-only beat is merged from the busy state once the output is
// free. A measure beat runs both lanes' serial units side by side: NCH multiply
// steps (NCH = ceil(COUNT_BITS/16), one 16 x 26 partial product each), then
// NCH*16+26 restoring divide steps of one quotient bit each, a saturate step
// and a merge step. One item is in work at a time and the next beat is taken
// the cycle after the merge. req_tready is also high while a finished result
// waits in the output register. Reset (synchronous, active high) clears
// counters, snapshots, previous A levels and loads the register reset values.
// A stalled receiver holds the result beat; the next finished result waits in
// the lanes until it is taken.
`default_nettype none
module dual_encoder_counter_velocity_core #(
   parameter int COUNT_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   // Input channel
   input  wire         req_tvalid,
   output logic        req_tready,
   // [0] left_a, [1] left_b, [2] right_a, [3] right_b, [23:4] interval_us
   input  wire [23:0]  req_tdata,
   // [0] func
   input  wire [0:0]   req_tuser,
   // Result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [31:0] left_ticks, [63:32] right_ticks, [95:64] left_speed_mm_s,
   // [127:96] right_speed_mm_s
   output logic [127:0] rsp_tdata,
   // [0] speed_valid
   output logic [0:0]  rsp_tuser,
   // Configuration port
   input  wire         csr_we,
   input  wire [1:0]   csr_addr,
   input  wire [15:0]  csr_wdata
);
   import decv_pkg::*;

   localparam logic T_IDLE = 1'b0;
   localparam logic T_BUSY = 1'b1;

   logic        state_ff, state_in;
   logic        func_ff, func_in;
   logic        out_valid_ff, out_valid_in;
   logic [127:0] out_data_ff, out_data_in;
   logic        out_user_ff, out_user_in;
   logic [15:0] dist_ff;
   logic        lpol_ff;
   logic        rpol_ff;

   logic                 accept;
   logic [K_BITS-1:0]    k_scale;
   lane_cmd_type         left_cmd, right_cmd;
   lane_status_type      left_st, right_st;
   logic                 merge;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DISTANCE_RESET;
         lpol_ff <= LEFT_POLARITY_RESET;
         rpol_ff <= RIGHT_POLARITY_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_DISTANCE_PER_TICK: dist_ff <= csr_wdata;
            REG_LEFT_POLARITY:     lpol_ff <= csr_wdata[0];
            REG_RIGHT_POLARITY:    rpol_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign k_scale    = K_BITS'(dist_ff) * K_BITS'(MM_SCALE);
   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Lane commands
   always_comb begin
      left_cmd.step  = accept;
      left_cmd.func  = req_tuser[0];
      left_cmd.a     = req_tdata[0];
      left_cmd.b     = req_tdata[1];
      left_cmd.pol   = lpol_ff;
      right_cmd.step = accept;
      right_cmd.func = req_tuser[0];
      right_cmd.a    = req_tdata[2];
      right_cmd.b    = req_tdata[3];
      right_cmd.pol  = rpol_ff;
   end

   decv_lane #(.COUNT_BITS(COUNT_BITS)) u_left (
      .clock       (clock),
      .reset       (reset),
      .cmd         (left_cmd),
      .interval_us (req_tdata[23:4]),
      .k_scale     (k_scale),
      .status      (left_st)
   );

   decv_lane #(.COUNT_BITS(COUNT_BITS)) u_right (
      .clock       (clock),
      .reset       (reset),
      .cmd         (right_cmd),
      .interval_us (req_tdata[23:4]),
      .k_scale     (k_scale),
      .status      (right_st)
   );

   // Merge lane results into the output register
   assign merge = (state_ff == T_BUSY) && left_st.done && right_st.done
                  && (!out_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               func_in  = req_tuser[0];
               state_in = T_BUSY;
            end
         end
         T_BUSY: begin
            if (merge) begin
               out_valid_in = 1'b1;
               out_data_in  = {right_st.speed, left_st.speed,
                               right_st.ticks, left_st.ticks};
               out_user_in  = func_ff;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_user_ff;

endmodule
`default_nettype wire

@@ hdl/decv_lane.sv @@
// One encoder lane: x1 tick counter, measure snapshot and serial velocity unit.
`default_nettype none
module decv_lane #(
   parameter int COUNT_BITS = 32
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire decv_pkg::lane_cmd_type cmd,
   input  wire [decv_pkg::IV_BITS-1:0] interval_us,
   input  wire [decv_pkg::K_BITS-1:0]  k_scale,
   output decv_pkg::lane_status_type   status
);
   import decv_pkg::*;

   localparam int CHUNK = 16;
   localparam int NCH   = (COUNT_BITS + CHUNK - 1) / CHUNK;
   localparam int MAGW  = NCH * CHUNK;
   localparam int PW    = MAGW + K_BITS;
   localparam int CW    = $clog2(PW + 1);

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_MUL  = 2'd1;
   localparam logic [1:0] L_DIV  = 2'd2;
   localparam logic [1:0] L_FIN  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] snap_ff, snap_in;
   logic                  prev_a_ff, prev_a_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [MAGW-1:0]       mag_ff, mag_in;
   logic [PW-1:0]         acc_ff, acc_in;
   logic [IV_BITS-1:0]    rem_ff, rem_in;
   logic [IV_BITS-1:0]    iv_ff, iv_in;
   logic [K_BITS-1:0]     k_ff, k_in;
   logic                  neg_ff, neg_in;
   logic [31:0]           speed_ff, speed_in;

   logic [COUNT_BITS-1:0] stepped;
   logic [COUNT_BITS-1:0] delta;
   logic [COUNT_BITS-1:0] delta_mag;
   logic [CHUNK-1:0]      chunk;
   logic [CHUNK+K_BITS-1:0] prod;
   logic [IV_BITS:0]      rem_sh;
   logic                  rem_ge;
   logic                  q_ovf;
   logic [31:0]           q_low;
   logic [31:0]           limit;
   logic [31:0]           v_sat;

   // Counter step on a rising edge of A
   always_comb begin
      stepped = count_ff;
      if (cmd.a && !prev_a_ff) begin
         if (cmd.b ^ cmd.pol) begin
            stepped = count_ff - COUNT_BITS'(1);
         end else begin
            stepped = count_ff + COUNT_BITS'(1);
         end
      end
      delta     = stepped - snap_ff;
      delta_mag = delta[COUNT_BITS-1] ? (COUNT_BITS'(0) - delta) : delta;
   end

   // Datapath terms of the multiply and divide steps
   always_comb begin
      chunk  = mag_ff[MAGW-1 -: CHUNK];
      prod   = chunk * k_ff;
      rem_sh = {rem_ff, acc_ff[PW-1]};
      rem_ge = rem_sh >= {1'b0, iv_ff};
      q_ovf  = |acc_ff[PW-1:32];
      q_low  = acc_ff[31:0];
      limit  = neg_ff ? NEG_LIMIT : POS_LIMIT;
      v_sat  = (q_ovf || (q_low > limit)) ? limit : q_low;
   end

   // Lane sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      snap_in   = snap_ff;
      prev_a_in = prev_a_ff;
      cnt_in    = cnt_ff;
      mag_in    = mag_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      iv_in     = iv_ff;
      k_in      = k_ff;
      neg_in    = neg_ff;
      speed_in  = speed_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (cmd.step) begin
               count_in  = stepped;
               prev_a_in = cmd.a;
               speed_in  = 32'd0;
               if (cmd.func) begin
                  snap_in  = stepped;
                  neg_in   = delta[COUNT_BITS-1];
                  mag_in   = MAGW'(delta_mag);
                  acc_in   = '0;
                  rem_in   = '0;
                  iv_in    = interval_us;
                  k_in     = k_scale;
                  cnt_in   = '0;
                  state_in = L_MUL;
               end
            end
         end
         L_MUL: begin
            mag_in = mag_ff << CHUNK;
            acc_in = (acc_ff << CHUNK) + PW'(prod);
            if (cnt_ff == CW'(NCH - 1)) begin
               cnt_in   = '0;
               state_in = L_DIV;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         L_DIV: begin
            acc_in = {acc_ff[PW-2:0], rem_ge};
            rem_in = rem_ge ? IV_BITS'(rem_sh - {1'b0, iv_ff}) : IV_BITS'(rem_sh);
            if (cnt_ff == CW'(PW - 1)) begin
               state_in = L_FIN;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         L_FIN: begin
            if (iv_ff == '0) begin
               speed_in = 32'd0;
            end else begin
               speed_in = neg_ff ? (32'd0 - v_sat) : v_sat;
            end
            state_in = L_IDLE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= L_IDLE;
         count_ff  <= '0;
         snap_ff   <= '0;
         prev_a_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         snap_ff   <= snap_in;
         prev_a_ff <= prev_a_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      iv_ff    <= iv_in;
      k_ff     <= k_in;
      neg_ff   <= neg_in;
      speed_ff <= speed_in;
   end

   assign status.done  = (state_ff == L_IDLE);
   assign status.ticks = 32'($signed(count_ff));
   assign status.speed = speed_ff;

endmodule
`default_nettype wire

@@ verif/dual_encoder_counter_velocity_checker.sv @@
// Scoreboard for the dual encoder core: tracks counts and checks every result beat.
`default_nettype none
module dual_encoder_counter_velocity_checker (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   // [0] left_a, [1] left_b, [2] right_a, [3] right_b, [23:4] interval_us
   input  wire [23:0]   req_tdata,
   // [0] func
   input  wire [0:0]    req_tuser,
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   // [31:0] left_ticks, [63:32] right_ticks, [95:64] left_speed, [127:96] right_speed
   input  wire [127:0]  rsp_tdata,
   // [0] speed_valid
   input  wire [0:0]    rsp_tuser,
   input  wire          csr_we,
   input  wire [1:0]    csr_addr,
   input  wire [15:0]   csr_wdata,
   output int           mismatches,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import decv_pkg::*;

   typedef struct packed {
      logic [31:0] left_ticks;
      logic [31:0] right_ticks;
      logic [31:0] left_speed;
      logic [31:0] right_speed;
      logic        speed_valid;
   } encoder_reading_type;

   // Readings predicted for accepted beats, oldest first
   encoder_reading_type readings_due[$];

   // Mirror of the core's registers and state
   logic [15:0] dist_um;
   logic        left_pol;
   logic        right_pol;
   logic [31:0] left_count;
   logic [31:0] right_count;
   logic [31:0] left_mark;
   logic [31:0] right_mark;
   logic        left_a_last;
   logic        right_a_last;

   // x1 decode: only a rising A moves the count, B xor polarity picks down
   function automatic logic [31:0] step_count(input logic [31:0] count, input logic a,
                                              input logic a_last, input logic b,
                                              input logic pol);
      if (a && !a_last)
         return (b ^ pol) ? count - 32'd1 : count + 32'd1;
      return count;
   endfunction

   // ticks * um/tick / us, scaled to mm/s, truncated toward zero, saturated
   function automatic logic [31:0] speed_mm_s(input logic [31:0] delta,
                                              input logic [IV_BITS-1:0] iv,
                                              input logic [15:0] tick_um);
      logic [63:0] k;
      logic [63:0] mag;
      logic [63:0] lim;
      logic [63:0] v;
      logic        neg;
      k   = 64'(tick_um) * 64'd1000;
      neg = delta[31];
      mag = {32'd0, neg ? (~delta + 32'd1) : delta};
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (iv == '0 || k == '0)
         return '0;
      v = (mag * k) / 64'(iv);
      if (v > lim)
         v = lim;
      return neg ? (~v[31:0] + 32'd1) : v[31:0];
   endfunction

   task automatic note_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch in %s: got %0d, expected %0d at %0t", field,
               $signed(got), $signed(want), $time);
      mismatches++;
   endtask

   always @(posedge clock) begin
      encoder_reading_type seen;
      encoder_reading_type want;
      if (reset) begin
         dist_um      = DISTANCE_RESET;
         left_pol     = LEFT_POLARITY_RESET;
         right_pol    = RIGHT_POLARITY_RESET;
         left_count   = '0;
         right_count  = '0;
         left_mark    = '0;
         right_mark   = '0;
         left_a_last  = 1'b0;
         right_a_last = 1'b0;
         mismatches   = 0;
         readings_due.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_addr)
               REG_DISTANCE_PER_TICK: dist_um   = csr_wdata;
               REG_LEFT_POLARITY:     left_pol  = csr_wdata[0];
               REG_RIGHT_POLARITY:    right_pol = csr_wdata[0];
               default: ;
            endcase
         end

         // result beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen.left_ticks  = rsp_tdata[31:0];
            seen.right_ticks = rsp_tdata[63:32];
            seen.left_speed  = rsp_tdata[95:64];
            seen.right_speed = rsp_tdata[127:96];
            seen.speed_valid = rsp_tuser[0];
            if (readings_due.size() == 0) begin
               note_mismatch("unexpected result beat, left_ticks", seen.left_ticks, '0);
            end else begin
               want = readings_due.pop_front();
               if (seen.left_ticks !== want.left_ticks)
                  note_mismatch("left_ticks", seen.left_ticks, want.left_ticks);
               if (seen.right_ticks !== want.right_ticks)
                  note_mismatch("right_ticks", seen.right_ticks, want.right_ticks);
               if (seen.left_speed !== want.left_speed)
                  note_mismatch("left_speed_mm_s", seen.left_speed, want.left_speed);
               if (seen.right_speed !== want.right_speed)
                  note_mismatch("right_speed_mm_s", seen.right_speed, want.right_speed);
               if (seen.speed_valid !== want.speed_valid)
                  note_mismatch("speed_valid", 32'(seen.speed_valid),
                                32'(want.speed_valid));
            end
         end

         // input beat: step counters first, then measure on updated counts
         if (req_tvalid && req_tready) begin
            left_count   = step_count(left_count, req_tdata[0], left_a_last,
                                      req_tdata[1], left_pol);
            right_count  = step_count(right_count, req_tdata[2], right_a_last,
                                      req_tdata[3], right_pol);
            left_a_last  = req_tdata[0];
            right_a_last = req_tdata[2];
            want.speed_valid = req_tuser[0];
            want.left_speed  = '0;
            want.right_speed = '0;
            if (req_tuser[0]) begin
               want.left_speed  = speed_mm_s(left_count - left_mark, req_tdata[23:4],
                                             dist_um);
               want.right_speed = speed_mm_s(right_count - right_mark, req_tdata[23:4],
                                             dist_um);
               left_mark  = left_count;
               right_mark = right_count;
            end
            want.left_ticks  = left_count;
            want.right_ticks = right_count;
            readings_due.push_back(want);
         end
      end
      pending <= readings_due.size();
   end

endmodule
`default_nettype wire

@@ verif/dual_encoder_counter_velocity_core_tb.sv @@
// Testbench top: drives encoder samples and register writes into the core, prints the verdict.
`default_nettype none
module dual_encoder_counter_velocity_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import decv_pkg::*;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   wire          req_tready;
   // [0] left_a, [1] left_b, [2] right_a, [3] right_b, [23:4] interval_us
   logic [23:0]  req_tdata  = '0;
   // [0] func
   logic [0:0]   req_tuser  = '0;
   wire          rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [31:0] left_ticks, [63:32] right_ticks, [95:64] left_speed, [127:96] right_speed
   wire  [127:0] rsp_tdata;
   // [0] speed_valid
   wire  [0:0]   rsp_tuser;
   logic         csr_we     = 1'b0;
   logic [1:0]   csr_addr   = REG_DISTANCE_PER_TICK;
   logic [15:0]  csr_wdata  = '0;

   int           mismatches;
   int           pending;

   // no idling on either side once set
   logic         quiet = 1'b0;
   int           beats_sent = 0;
   int           measures_sent = 0;
   int           settings_used = 1;

   // encoder motion state per side
   logic [1:0]   left_phase  = '0;
   logic [1:0]   right_phase = '0;
   logic         left_a  = 1'b0;
   logic         left_b  = 1'b0;
   logic         right_a = 1'b0;
   logic         right_b = 1'b0;

   dual_encoder_counter_velocity_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   dual_encoder_counter_velocity_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // receiver stalls in bursts
   always begin
      @(posedge clock);
      if (!quiet && !reset && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   // one input beat, with an optional gap ahead of it
   task automatic send_beat(input logic func, input logic la, input logic lb,
                            input logic ra, input logic rb,
                            input logic [IV_BITS-1:0] iv);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {iv, rb, ra, lb, la};
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      if (func)
         measures_sent++;
   endtask

   // stop sending and wait until every result is back and the core is idle
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_registers(input logic [15:0] tick_um, input logic lp, input logic rp);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= REG_DISTANCE_PER_TICK;
      csr_wdata <= tick_um;
      @(posedge clock);
      csr_addr  <= REG_LEFT_POLARITY;
      csr_wdata <= {15'd0, lp};
      @(posedge clock);
      csr_addr  <= REG_RIGHT_POLARITY;
      csr_wdata <= {15'd0, rp};
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [IV_BITS-1:0] pick_interval();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 20'd1;
         2:       return '1;
         3:       return 20'($urandom_range(1, 16));
         4, 5, 6: return 20'($urandom_range(1, 1000000));
         default: return 20'($urandom);
      endcase
   endfunction

   // modes: 0-2 forward quadrature, 3-5 backward, 6 toggle A only, 7 pin noise
   task automatic move_side(input int mode, inout logic [1:0] phase,
                            inout logic a, inout logic b);
      case (mode)
         0, 1, 2: if ($urandom_range(0, 7) != 0) phase = phase + 2'd1;
         3, 4, 5: if ($urandom_range(0, 7) != 0) phase = phase - 2'd1;
         6:       a = ~a;
         default: {a, b} = 2'($urandom);
      endcase
      // gray sequence (A,B): 00, 10, 11, 01
      if (mode < 6) begin
         a = phase[1] ^ phase[0];
         b = phase[1];
      end
   endtask

   // spans of coherent motion, each closed by a measure, a few measures inside
   task automatic run_motion(input int count);
      int   sent;
      int   span;
      int   left_mode;
      int   right_mode;
      logic go;
      sent = 0;
      while (sent < count) begin
         span = $urandom_range(1, 120);
         if (span > count - sent)
            span = count - sent;
         left_mode  = $urandom_range(0, 7);
         right_mode = $urandom_range(0, 7);
         for (int i = 0; i < span; i++) begin
            move_side(left_mode, left_phase, left_a, left_b);
            move_side(right_mode, right_phase, right_a, right_b);
            go = (i == span - 1) || ($urandom_range(0, 63) == 0);
            send_beat(go, left_a, left_b, right_a, right_b,
                      go ? pick_interval() : 20'($urandom));
         end
         sent += span;
      end
   endtask

   // run limit
   initial begin
      #8ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first A high counts, both directions, negative counts
      send_beat(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 20'h00000);
      send_beat(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 20'hFFFFF);
      send_beat(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 20'h00000);
      send_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 20'h00000);
      send_beat(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 20'h00000);
      // measure with zero interval, snapshots still taken
      send_beat(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 20'h00000);
      send_beat(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 20'h00000);
      // edge and measure in one beat, shortest interval
      send_beat(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 20'd1);
      send_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 20'hFFFFF);
      send_beat(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 20'd7);
      // negative speed truncates toward zero
      send_beat(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 20'd1000000);
      send_beat(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 20'd5);
      send_beat(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 20'd3);

      run_motion(380);

      // largest distance, flipped polarities: saturation both ways
      set_registers(16'hFFFF, 1'b1, 1'b0);
      run_motion(450);

      // zero distance gives zero speed
      set_registers(16'h0000, 1'b0, 1'b0);
      run_motion(200);

      set_registers(16'h0001, 1'b1, 1'b1);
      drain();
      // receiver back-pressure and sender gaps, sender waits on the drain
      run_motion(350);

      set_registers(16'($urandom_range(1, 65535)), 1'($urandom), 1'($urandom));
      run_motion(250);

      // last stretch without idling on either side
      set_registers(16'hFFFF, 1'b0, 1'b1);
      quiet = 1'b1;
      run_motion(300);

      drain();
      repeat (80) @(posedge clock);

      $display("Covered %0d sample beats, %0d of them measures, under %0d register settings",
               beats_sent, measures_sent, settings_used);
      $display("Included zero interval, zero distance and saturated speeds");
      if (mismatches == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire
